/* sv/circle_box_collision_slide_macros.svh */
// ----------------------------------------------------------------------------
// circle_box_collision_slide_macros
// Assertion macros for the collision block.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_BOX_COLLISION_SLIDE_MACROS_SVH
`define CIRCLE_BOX_COLLISION_SLIDE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CBC_ASSERT_IMPL(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("check failed");
`define CBC_ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("check failed");
`else
`define CBC_ASSERT_IMPL(label, clk, rstn, a, c)
`define CBC_ASSERT_NEXT(label, clk, rstn, a, c)
`endif
`endif

/* sv/cbc_pkg.sv */
// ----------------------------------------------------------------------------
// cbc_pkg
// Types and constants shared by the collision block.
// ----------------------------------------------------------------------------
package cbc_pkg;
    localparam int MAX_BOXES_DEF  = 64;
    localparam int COORD_BITS_DEF = 24;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = COORD_BITS_DEF;
    localparam int RAD_BITS       = 15;
    localparam int CNT_BITS       = 7;
    localparam int SLAB_BELOW     = 64;
    localparam int SLAB_ABOVE     = 384;

    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_X  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_X  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_Z  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_Z  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_BVALID = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_COUNT  = 3'd6;

    localparam logic [1:0] OUT_KEPT = 2'd0;
    localparam logic [1:0] OUT_XSL  = 2'd1;
    localparam logic [1:0] OUT_ZSL  = 2'd2;
    localparam logic [1:0] OUT_PREV = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE, ST_START, ST_SCAN, ST_WAIT, ST_DONE, ST_OUT
    } state_t;

    typedef struct packed {
        logic       start_try;  // load trial position for try
        logic [1:0] try_sel;
        logic       scan_en;    // check one box this cycle
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic last;
        logic none;
        logic busy;
    } stat_t;
endpackage

/* sv/circle_box_collision_slide.sv */
// ----------------------------------------------------------------------------
// circle_box_collision_slide
// Circle against a table of boxes, trying candidate, x slide, z slide, previous.
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// s_        in   s_valid/s_ready    operation, entry_index, first_*, second_*
// m_        out  m_valid/m_ready    resolved_x/y/z, outcome
// cfg       in   cfg_we             cfg_index, cfg_data
// A move scans the table once per try: start, N box reads, a pipeline drain
// and a decision state, N the box count. At most three tries scan; falling
// back to the previous position adds only a start and a decision state.
// Result is held in m_ until taken; no new request is taken meanwhile.
// Reset is synchronous; the table is not cleared.
module circle_box_collision_slide #(
    parameter int MAX_BOXES  = cbc_pkg::MAX_BOXES_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [cbc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [cbc_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_operation,
    input  logic [5:0]                            s_entry_index,
    input  logic signed [cbc_pkg::COORD_BITS_DEF-1:0] s_first_x,
    input  logic signed [cbc_pkg::COORD_BITS_DEF-1:0] s_first_y,
    input  logic signed [cbc_pkg::COORD_BITS_DEF-1:0] s_first_z,
    input  logic signed [cbc_pkg::COORD_BITS_DEF-1:0] s_second_x,
    input  logic signed [cbc_pkg::COORD_BITS_DEF-1:0] s_second_y,
    input  logic signed [cbc_pkg::COORD_BITS_DEF-1:0] s_second_z,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [cbc_pkg::COORD_BITS_DEF-1:0] m_resolved_x,
    output logic signed [cbc_pkg::COORD_BITS_DEF-1:0] m_resolved_y,
    output logic signed [cbc_pkg::COORD_BITS_DEF-1:0] m_resolved_z,
    output logic [1:0]                            m_outcome
);
    import cbc_pkg::*;
    `include "circle_box_collision_slide_macros.svh"

    localparam int COORD_BITS = COORD_BITS_DEF;

    logic signed [COORD_BITS-1:0] wmin_x_reg, wmax_x_reg, wmin_z_reg, wmax_z_reg;
    logic bvalid_reg;
    logic [RAD_BITS-1:0] radius_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic idle, take, move_take, out_wait;
    cmd_t cmd;
    stat_t stat;
    logic signed [COORD_BITS-1:0] fi [3];
    logic signed [COORD_BITS-1:0] se [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wmin_x_reg <= '0; wmax_x_reg <= '0; wmin_z_reg <= '0; wmax_z_reg <= '0;
            bvalid_reg <= 1'b0; radius_reg <= RAD_BITS'(256); count_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MIN_X:  wmin_x_reg <= cfg_data[COORD_BITS-1:0];
                REG_MAX_X:  wmax_x_reg <= cfg_data[COORD_BITS-1:0];
                REG_MIN_Z:  wmin_z_reg <= cfg_data[COORD_BITS-1:0];
                REG_MAX_Z:  wmax_z_reg <= cfg_data[COORD_BITS-1:0];
                REG_BVALID: bvalid_reg <= cfg_data[0];
                REG_RADIUS: radius_reg <= cfg_data[RAD_BITS-1:0];
                REG_COUNT:  count_reg  <= cfg_data[CNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign s_ready   = idle;
    assign take      = s_valid && s_ready;
    assign move_take = take && s_operation;
    assign out_wait  = m_valid && !m_ready;
    assign fi[0] = s_first_x;  assign fi[1] = s_first_y;  assign fi[2] = s_first_z;
    assign se[0] = s_second_x; assign se[1] = s_second_y; assign se[2] = s_second_z;

    cbc_datapath #(.MAX_BOXES(MAX_BOXES), .COORD_BITS(COORD_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .load_we(take && !s_operation), .load_idx(s_entry_index),
        .in_first(fi), .in_second(se), .in_take(move_take),
        .wmin_x(wmin_x_reg), .wmax_x(wmax_x_reg), .wmin_z(wmin_z_reg),
        .wmax_z(wmax_z_reg), .bvalid(bvalid_reg), .radius(radius_reg),
        .count(count_reg), .cmd(cmd), .stat(stat),
        .trial_x(m_resolved_x), .trial_y(m_resolved_y), .trial_z(m_resolved_z)
    );

    cbc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .move_take(move_take),
        .out_take(m_valid && m_ready), .stat(stat), .cmd(cmd),
        .idle(idle), .out_valid(m_valid), .outcome(m_outcome)
    );

    `CBC_ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, m_valid, !s_ready)
    `CBC_ASSERT_NEXT(a_hold_out, aclk, aresetn, out_wait, m_valid && $stable(m_resolved_x))
    `CBC_ASSERT_IMPL(a_scan_cmd, aclk, aresetn, cmd.scan_en, !cmd.start_try)
endmodule

/* sv/cbc_ram.sv */
// ----------------------------------------------------------------------------
// cbc_ram
// Generic single-port-write RAM with registered read.
// ----------------------------------------------------------------------------
module cbc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* sv/cbc_datapath.sv */
// ----------------------------------------------------------------------------
// cbc_datapath
// Box table, trial position, and a three-stage per-box hit pipeline.
// ----------------------------------------------------------------------------
module cbc_datapath #(
    parameter int MAX_BOXES  = 64,
    parameter int COORD_BITS = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           load_we,
    input  logic [5:0]                     load_idx,
    input  logic signed [COORD_BITS-1:0]   in_first [3],
    input  logic signed [COORD_BITS-1:0]   in_second [3],
    input  logic                           in_take,
    input  logic signed [COORD_BITS-1:0]   wmin_x,
    input  logic signed [COORD_BITS-1:0]   wmax_x,
    input  logic signed [COORD_BITS-1:0]   wmin_z,
    input  logic signed [COORD_BITS-1:0]   wmax_z,
    input  logic                           bvalid,
    input  logic [cbc_pkg::RAD_BITS-1:0]   radius,
    input  logic [cbc_pkg::CNT_BITS-1:0]   count,
    input  cbc_pkg::cmd_t                  cmd,
    output cbc_pkg::stat_t                 stat,
    output logic signed [COORD_BITS-1:0]   trial_x,
    output logic signed [COORD_BITS-1:0]   trial_y,
    output logic signed [COORD_BITS-1:0]   trial_z
);
    import cbc_pkg::*;
    localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam int W  = COORD_BITS + 2;
    localparam int DW = RAD_BITS + 1;

    logic signed [COORD_BITS-1:0] prev_reg [3];
    logic signed [COORD_BITS-1:0] cand_reg [3];
    logic signed [COORD_BITS-1:0] tx_reg, ty_reg, tz_reg;
    logic [CW-1:0] addr_reg, n_eff;
    logic hit_reg, v1_reg;
    logic [AW-1:0] raddr;
    logic [COORD_BITS-1:0] rd [6];
    logic we_ok;

    logic signed [W-1:0] px, pz, py, bx0, bx1, bz0, bz1, by0, by1, nx, nz, ddx, ddz;
    logic [W-1:0] ax, az;
    logic slab_ok, ok1_now;
    logic [DW-1:0] dx_reg, dz_reg;
    logic ok1_reg;
    logic [2*DW:0] sum_reg;
    logic [2*RAD_BITS-1:0] rr_reg;
    logic ok2_reg;

    assign we_ok = load_we && ({{(32-6){1'b0}}, load_idx} < MAX_BOXES);
    assign raddr = addr_reg[AW-1:0];

    for (genvar g = 0; g < 6; g++) begin : g_ram
        logic [COORD_BITS-1:0] wd;
        assign wd = (g < 3) ? in_first[g % 3] : in_second[g % 3];
        cbc_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_BOXES)) u_ram (
            .aclk(aclk), .we(we_ok), .waddr(AW'(load_idx)), .wdata(wd),
            .raddr(raddr), .rdata(rd[g])
        );
    end

    always_comb begin
        if ({{(32-CNT_BITS){1'b0}}, count} > MAX_BOXES) n_eff = CW'(MAX_BOXES);
        else n_eff = CW'(count);
    end

    // world clamp of one axis
    function automatic logic signed [COORD_BITS-1:0] clampw(
        input logic signed [COORD_BITS-1:0] v,
        input logic signed [COORD_BITS-1:0] wl,
        input logic signed [COORD_BITS-1:0] wh,
        input logic [RAD_BITS-1:0] r, input logic en);
        logic signed [W-1:0] lo, hi, vv;
        lo = W'(wl) + $signed(W'(r));
        hi = W'(wh) - $signed(W'(r));
        vv = W'(v);
        clampw = v;
        if (en && lo < hi) begin
            if (vv < lo) clampw = lo[COORD_BITS-1:0];
            else if (vv > hi) clampw = hi[COORD_BITS-1:0];
        end
    endfunction

    always_ff @(posedge aclk) begin
        if (in_take) begin
            for (int k = 0; k < 3; k++) begin
                prev_reg[k] <= in_first[k];
                cand_reg[k] <= in_second[k];
            end
        end
        if (cmd.start_try) begin
            case (cmd.try_sel)
                OUT_KEPT: begin
                    tx_reg <= clampw(cand_reg[0], wmin_x, wmax_x, radius, bvalid);
                    ty_reg <= cand_reg[1];
                    tz_reg <= clampw(cand_reg[2], wmin_z, wmax_z, radius, bvalid);
                end
                OUT_XSL: begin
                    tx_reg <= clampw(cand_reg[0], wmin_x, wmax_x, radius, bvalid);
                    ty_reg <= prev_reg[1];
                    tz_reg <= clampw(prev_reg[2], wmin_z, wmax_z, radius, bvalid);
                end
                OUT_ZSL: begin
                    tx_reg <= clampw(prev_reg[0], wmin_x, wmax_x, radius, bvalid);
                    ty_reg <= prev_reg[1];
                    tz_reg <= clampw(cand_reg[2], wmin_z, wmax_z, radius, bvalid);
                end
                default: begin
                    tx_reg <= clampw(prev_reg[0], wmin_x, wmax_x, radius, bvalid);
                    ty_reg <= prev_reg[1];
                    tz_reg <= clampw(prev_reg[2], wmin_z, wmax_z, radius, bvalid);
                end
            endcase
        end
    end

    // stage 1: nearest-point distances, slab check
    always_comb begin
        px = W'(tx_reg); py = W'(ty_reg); pz = W'(tz_reg);
        bx0 = W'($signed(rd[0])); by0 = W'($signed(rd[1])); bz0 = W'($signed(rd[2]));
        bx1 = W'($signed(rd[3])); by1 = W'($signed(rd[4])); bz1 = W'($signed(rd[5]));
        nx = (px < bx0) ? bx0 : ((px > bx1) ? bx1 : px);
        nz = (pz < bz0) ? bz0 : ((pz > bz1) ? bz1 : pz);
        ddx = px - nx; ddz = pz - nz;
        ax = ddx[W-1] ? W'(-ddx) : W'(ddx);
        az = ddz[W-1] ? W'(-ddz) : W'(ddz);
        slab_ok = !((py + W'(SLAB_BELOW) < by0) || (py - W'(SLAB_ABOVE) > by1));
        ok1_now = slab_ok && ax <= W'(radius) && az <= W'(radius);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg <= '0; v1_reg <= 1'b0; hit_reg <= 1'b0;
        end else begin
            if (cmd.start_try) begin
                addr_reg <= '0;
            end else if (cmd.scan_en) begin
                addr_reg <= addr_reg + 1'b1;
            end
            v1_reg <= cmd.scan_en;           // read data valid next cycle
            if (cmd.start_try) begin
                hit_reg <= 1'b0;
            end else if (ok2_reg && sum_reg <= (2*DW+1)'(rr_reg)) begin
                hit_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        dx_reg  <= ax[DW-1:0];
        dz_reg  <= az[DW-1:0];
        ok1_reg <= v1_reg && ok1_now;
        sum_reg <= (2*DW+1)'((2*DW)'(dx_reg) * (2*DW)'(dx_reg)) +
                   (2*DW+1)'((2*DW)'(dz_reg) * (2*DW)'(dz_reg));
        rr_reg  <= (2*RAD_BITS)'(radius) * (2*RAD_BITS)'(radius);
        ok2_reg <= ok1_reg;
    end

    assign stat.hit  = hit_reg;
    assign stat.last = cmd.scan_en && (addr_reg + 1'b1 >= n_eff);
    assign stat.none = (n_eff == '0);
    assign stat.busy = v1_reg || ok1_reg || ok2_reg;
    assign trial_x = tx_reg;
    assign trial_y = ty_reg;
    assign trial_z = tz_reg;
endmodule

/* sv/cbc_ctrl.sv */
// ----------------------------------------------------------------------------
// cbc_ctrl
// Sequencer over the four tried positions.
// ----------------------------------------------------------------------------
module cbc_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           move_take,
    input  logic           out_take,
    input  cbc_pkg::stat_t stat,
    output cbc_pkg::cmd_t  cmd,
    output logic           idle,
    output logic           out_valid,
    output logic [1:0]     outcome
);
    import cbc_pkg::*;
    state_t st_reg, st_next;
    logic [1:0] try_reg, try_next;

    always_comb begin
        st_next = st_reg; try_next = try_reg;
        case (st_reg)
            ST_IDLE:  if (move_take) begin st_next = ST_START; try_next = OUT_KEPT; end
            ST_START: st_next = (stat.none || try_reg == OUT_PREV) ? ST_DONE : ST_SCAN;
            ST_SCAN:  if (stat.last) st_next = ST_WAIT;
            ST_WAIT:  if (!stat.busy) st_next = ST_DONE;
            ST_DONE: begin
                if (stat.hit && try_reg != OUT_PREV) begin
                    try_next = try_reg + 2'd1;
                    st_next  = ST_START;
                end else begin
                    st_next = ST_OUT;
                end
            end
            ST_OUT:   if (out_take) st_next = ST_IDLE;
            default:  st_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.start_try = (st_reg == ST_START);
        cmd.try_sel   = try_reg;
        cmd.scan_en   = (st_reg == ST_SCAN);
        idle          = (st_reg == ST_IDLE);
        out_valid     = (st_reg == ST_OUT);
        outcome       = try_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE; try_reg <= OUT_KEPT;
        end else begin
            st_reg <= st_next; try_reg <= try_next;
        end
    end
endmodule

/* test/cbc_checker.sv */
// ----------------------------------------------------------------------------
// cbc_checker
// Watches the request, result and register ports of the collision block,
// predicts each move result and compares it field by field.
// ----------------------------------------------------------------------------
module cbc_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_operation,
    input  logic [5:0]         s_entry_index,
    input  logic signed [23:0] s_first_x,
    input  logic signed [23:0] s_first_y,
    input  logic signed [23:0] s_first_z,
    input  logic signed [23:0] s_second_x,
    input  logic signed [23:0] s_second_y,
    input  logic signed [23:0] s_second_z,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [23:0] m_resolved_x,
    input  logic signed [23:0] m_resolved_y,
    input  logic signed [23:0] m_resolved_z,
    input  logic [1:0]         m_outcome,
    output int                 errors,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import cbc_pkg::*;

    typedef struct {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic [1:0]         outcome;
    } position_t;

    longint box_lo_x [64], box_hi_x [64];
    longint box_lo_y [64], box_hi_y [64];
    longint box_lo_z [64], box_hi_z [64];
    longint wmin_x, wmax_x, wmin_z, wmax_z, radius, box_count;
    bit     bounds_on;
    position_t resolved_q[$];

    function automatic longint limit(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint fit_axis(longint v, longint wmin, longint wmax);
        longint lo, hi;
        lo = wmin + radius;
        hi = wmax - radius;
        if (bounds_on && lo < hi) return limit(v, lo, hi);
        return v;
    endfunction

    function automatic bit hits_box(longint px, longint py, longint pz);
        longint n, dx, dz;
        n = (box_count > 64) ? 64 : box_count;
        for (int i = 0; i < n; i++) begin
            if (py + SLAB_BELOW < box_lo_y[i] || py - SLAB_ABOVE > box_hi_y[i]) continue;
            dx = px - limit(px, box_lo_x[i], box_hi_x[i]);
            dz = pz - limit(pz, box_lo_z[i], box_hi_z[i]);
            if (dx < 0) dx = -dx;
            if (dz < 0) dz = -dz;
            if (dx > radius || dz > radius) continue;
            if (dx * dx + dz * dz <= radius * radius) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic position_t resolve_move(longint ox, longint oy, longint oz,
                                               longint cx, longint cy, longint cz);
        position_t p;
        longint tx, ty, tz;
        logic [1:0] oc;
        cx = fit_axis(cx, wmin_x, wmax_x);
        cz = fit_axis(cz, wmin_z, wmax_z);
        tx = cx; ty = cy; tz = cz; oc = OUT_KEPT;
        if (hits_box(tx, ty, tz)) begin
            tx = cx; ty = oy; tz = fit_axis(oz, wmin_z, wmax_z); oc = OUT_XSL;
            if (hits_box(tx, ty, tz)) begin
                tx = fit_axis(ox, wmin_x, wmax_x); ty = oy; tz = cz; oc = OUT_ZSL;
                if (hits_box(tx, ty, tz)) begin
                    tx = fit_axis(ox, wmin_x, wmax_x); ty = oy;
                    tz = fit_axis(oz, wmin_z, wmax_z); oc = OUT_PREV;
                end
            end
        end
        p.x = tx[23:0]; p.y = ty[23:0]; p.z = tz[23:0]; p.outcome = oc;
        return p;
    endfunction

    always @(posedge aclk) begin
        position_t want;
        if (!aresetn) begin
            wmin_x <= 0; wmax_x <= 0; wmin_z <= 0; wmax_z <= 0;
            bounds_on <= 1'b0; radius <= 256; box_count <= 0;
            resolved_q.delete();
            errors <= 0;
            pending <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_MIN_X:  wmin_x <= longint'($signed(cfg_data));
                    REG_MAX_X:  wmax_x <= longint'($signed(cfg_data));
                    REG_MIN_Z:  wmin_z <= longint'($signed(cfg_data));
                    REG_MAX_Z:  wmax_z <= longint'($signed(cfg_data));
                    REG_BVALID: bounds_on <= cfg_data[0];
                    REG_RADIUS: radius <= longint'(cfg_data[14:0]);
                    REG_COUNT:  box_count <= longint'(cfg_data[6:0]);
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (resolved_q.size() == 0) begin
                    $display("%0t: unexpected result x=%0d y=%0d z=%0d outcome=%0d",
                             $time, m_resolved_x, m_resolved_y, m_resolved_z, m_outcome);
                    errors <= errors + 1;
                end else begin
                    want = resolved_q.pop_front();
                    if (want.x !== m_resolved_x || want.y !== m_resolved_y ||
                        want.z !== m_resolved_z || want.outcome !== m_outcome) begin
                        $display("%0t: mismatch expected x=%0d y=%0d z=%0d outcome=%0d",
                                 $time, want.x, want.y, want.z, want.outcome);
                        $display("%0t:          actual   x=%0d y=%0d z=%0d outcome=%0d",
                                 $time, m_resolved_x, m_resolved_y, m_resolved_z,
                                 m_outcome);
                        errors <= errors + 1;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (!s_operation) begin
                    box_lo_x[s_entry_index] = s_first_x;
                    box_lo_y[s_entry_index] = s_first_y;
                    box_lo_z[s_entry_index] = s_first_z;
                    box_hi_x[s_entry_index] = s_second_x;
                    box_hi_y[s_entry_index] = s_second_y;
                    box_hi_z[s_entry_index] = s_second_z;
                end else begin
                    want = resolve_move(s_first_x, s_first_y, s_first_z,
                                        s_second_x, s_second_y, s_second_z);
                    resolved_q.insert(resolved_q.size(), want);
                end
            end
            pending <= resolved_q.size();
        end
    end
endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives box loads and moves into the collision block under a range of world
// bounds, radii and box counts, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cbc_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int         CYCLE_LIMIT = 1000000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [23:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_operation = 1'b0;
    logic [5:0]         s_entry_index = '0;
    logic signed [23:0] s_first_x = '0, s_first_y = '0, s_first_z = '0;
    logic signed [23:0] s_second_x = '0, s_second_y = '0, s_second_z = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [23:0] m_resolved_x, m_resolved_y, m_resolved_z;
    logic [1:0]         m_outcome;
    int                 errors, pending;
    bit                 quiet = 1'b0;
    int                 ready_hold = 0;
    int                 cycles = 0;

    circle_box_collision_slide u_dut (.*);
    cbc_checker u_chk (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Hold off the result side in bursts, never in the quiet tail.
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            m_ready <= 1'b0;
            ready_hold <= $urandom_range(1, 18);
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic logic signed [23:0] near(int lo, int hi);
        return 24'($signed($urandom_range(0, hi - lo)) + lo);
    endfunction

    task automatic send(logic op, logic [5:0] slot,
                        logic signed [23:0] ax, ay, az, bx, by, bz);
        s_valid <= 1'b1; s_operation <= op; s_entry_index <= slot;
        s_first_x <= ax; s_first_y <= ay; s_first_z <= az;
        s_second_x <= bx; s_second_y <= by; s_second_z <= bz;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
    endtask

    task automatic load_box(logic [5:0] slot);
        logic signed [23:0] lx, ly, lz, hx, hy, hz;
        lx = near(-3000, 3000); hx = lx + near(0, 1500);
        ly = near(-400, 200);   hy = ly + near(0, 600);
        lz = near(-3000, 3000); hz = lz + near(0, 1500);
        if ($urandom_range(0, 9) == 0) send(1'b0, slot, hx, hy, hz, lx, ly, lz);
        else send(1'b0, slot, lx, ly, lz, hx, hy, hz);
    endtask

    task automatic move_near();
        logic signed [23:0] px, py, pz;
        px = near(-3500, 3500); py = near(-600, 600); pz = near(-3500, 3500);
        send(1'b1, 6'($urandom), px, py, pz,
             px + near(-800, 800), py + near(-200, 200), pz + near(-800, 800));
    endtask

    task automatic noise_item();
        send(1'($urandom), 6'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
             24'($urandom), 24'($urandom), 24'($urandom));
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge aclk);
    endtask

    // Drain all results, let a trailing load finish, then rewrite every register.
    task automatic set_world(int variant);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        case (variant % 6)
            0: begin
                write_reg(REG_MIN_X, -24'sd4000); write_reg(REG_MAX_X, 24'sd4000);
                write_reg(REG_MIN_Z, -24'sd3000); write_reg(REG_MAX_Z, 24'sd3000);
                write_reg(REG_BVALID, 24'd1); write_reg(REG_RADIUS, 24'd256);
                write_reg(REG_COUNT, 24'd64);
            end
            1: begin
                write_reg(REG_MIN_X, 24'h800000); write_reg(REG_MAX_X, 24'h7FFFFF);
                write_reg(REG_MIN_Z, 24'h800000); write_reg(REG_MAX_Z, 24'h7FFFFF);
                write_reg(REG_BVALID, 24'd1); write_reg(REG_RADIUS, 24'd16384);
                write_reg(REG_COUNT, 24'd100);
            end
            2: begin
                write_reg(REG_MIN_X, 24'sd500); write_reg(REG_MAX_X, 24'sd600);
                write_reg(REG_MIN_Z, 24'sd300); write_reg(REG_MAX_Z, -24'sd300);
                write_reg(REG_BVALID, 24'd1); write_reg(REG_RADIUS, 24'd26);
                write_reg(REG_COUNT, 24'd0);
            end
            3: begin
                write_reg(REG_MIN_X, near(-5000, 0)); write_reg(REG_MAX_X, near(0, 5000));
                write_reg(REG_MIN_Z, near(-5000, 0)); write_reg(REG_MAX_Z, near(0, 5000));
                write_reg(REG_BVALID, 24'($urandom_range(0, 1)));
                write_reg(REG_RADIUS, 24'($urandom_range(26, 1200)));
                write_reg(REG_COUNT, 24'($urandom_range(1, 64)));
            end
            4: begin
                write_reg(REG_MIN_X, 24'h7FFFFF); write_reg(REG_MAX_X, 24'h800000);
                write_reg(REG_MIN_Z, 24'($urandom)); write_reg(REG_MAX_Z, 24'($urandom));
                write_reg(REG_BVALID, 24'hFFFFFE); write_reg(REG_RADIUS, 24'h7FFF);
                write_reg(REG_COUNT, 24'h7F);
            end
            default: begin
                write_reg(REG_MIN_X, -24'sd2000); write_reg(REG_MAX_X, 24'sd2500);
                write_reg(REG_MIN_Z, -24'sd2500); write_reg(REG_MAX_Z, 24'sd2000);
                write_reg(REG_BVALID, 24'd1);
                write_reg(REG_RADIUS, 24'($urandom_range(128, 700)));
                write_reg(REG_COUNT, 24'($urandom_range(16, 64)));
            end
        endcase
        write_reg(REG_UNUSED, 24'($urandom));
        cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fill the whole table first so no move ever reads an empty slot.
        send(1'b0, 6'd0, 24'sd500, -24'sd100, 24'sd500, -24'sd500, 24'sd300, -24'sd500);
        send(1'b0, 6'd63, 24'h800000, 24'h800000, 24'h800000,
             24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        for (int i = 1; i < 63; i++) load_box(6'(i));
        s_valid <= 1'b0;

        set_world(0);
        send(1'b1, 6'd0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
             24'h800000, 24'h800000, 24'h800000);
        send(1'b1, 6'd0, 24'h800000, 24'h800000, 24'h800000,
             24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        send(1'b1, 6'd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0);
        send(1'b1, 6'd0, -24'sd5000, 24'sd0, 24'sd0, 24'sd5000, 24'sd0, 24'sd0);
        send(1'b1, 6'd0, 24'sd0, 24'sd0, -24'sd5000, 24'sd0, 24'sd0, 24'sd5000);
        send(1'b1, 6'd0, 24'sd900, 24'sd50, 24'sd900, 24'sd700, 24'sd60, 24'sd700);
        set_world(1);
        send(1'b1, 6'd0, 24'sd100, 24'sd0, 24'sd100, 24'sd200, 24'sd0, 24'sd200);
        send(1'b1, 6'd0, 24'h7FFFFF, 24'sd0, 24'h800000, 24'h800000, 24'sd0, 24'h7FFFFF);
        set_world(2);
        send(1'b1, 6'd0, 24'sd0, 24'sd0, 24'sd0, 24'sd1000, 24'sd0, 24'sd1000);
        set_world(4);
        send(1'b1, 6'd0, 24'sd10, 24'sd0, 24'sd10, -24'sd10, 24'sd0, -24'sd10);

        for (int ph = 0; ph < 9; ph++) begin
            set_world(ph == 8 ? 0 : 3 + ph);
            // Hold idling off in the final phase.
            if (ph == 8) quiet = 1'b1;
            for (int k = 0; k < 42; k++) begin
                case ($urandom_range(0, 9))
                    0:       load_box(6'($urandom));
                    1:       noise_item();
                    default: move_near();
                endcase
            end
        end
        s_valid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule

/* sim.f */
+incdir+sv
sv/cbc_pkg.sv
sv/cbc_ram.sv
sv/cbc_datapath.sv
sv/cbc_ctrl.sv
sv/circle_box_collision_slide.sv
test/cbc_checker.sv
test/tb.sv
